// File: design/assert_macros.svh
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rpnp_pkg.sv
`timescale 1ns / 1ps
package rpnp_pkg;

  // Field widths
  localparam int SPECIES_W = 11;
  localparam int SITE_W    = 17;
  localparam int BIDX_W    = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = SITE_W;

  // Default sizing
  localparam int MAX_SPECIES_DEF = 1024;
  localparam int MAX_SITES_DEF   = 65536;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPECIES_TOTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SITE_TOTAL    = 2'd1;

  // Characters of interest
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [2:0] GAP_STATE = 3'd4;

  typedef enum logic [1:0] {
    KIND_NAME     = 2'd0,
    KIND_PACKED   = 2'd1,
    KIND_LINE_END = 2'd2,
    KIND_FINISH   = 2'd3
  } kind_t;

  typedef struct packed {
    logic       action;
    logic [7:0] text_byte;
  } item_t;

  typedef struct packed {
    kind_t                kind;
    logic [SPECIES_W-1:0] row_index;
    logic [BIDX_W-1:0]    byte_index;
    logic [7:0]           value;
    logic                 accepted;
    logic                 last;
  } result_t;

  // One input item's results: first always used, second only when two is set
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } pair_t;

  // Front-to-queue write beat
  typedef struct packed {
    logic  valid;
    pair_t entry;
  } pair_wr_t;

  function automatic logic [2:0] base_state(input logic [7:0] c);
    logic [2:0] st;
    unique case (c)
      "A", "a", "0": st = 3'd0;
      "C", "c", "1": st = 3'd1;
      "G", "g", "2": st = 3'd2;
      "T", "t", "3": st = 3'd3;
      default:       st = GAP_STATE;
    endcase
    return st;
  endfunction

  function automatic result_t make_result(input kind_t kind,
                                          input logic [SPECIES_W-1:0] row,
                                          input logic [BIDX_W-1:0] bidx,
                                          input logic [7:0] val,
                                          input logic acc,
                                          input logic lst);
    result_t r;
    r.kind       = kind;
    r.row_index  = row;
    r.byte_index = bidx;
    r.value      = val;
    r.accepted   = acc;
    r.last       = lst;
    return r;
  endfunction

endpackage

// File: design/rpnp_front.sv
`timescale 1ns / 1ps
module rpnp_front #(
  parameter int MAX_SPECIES = 1024,
  parameter int MAX_SITES   = 65536
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [rpnp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rpnp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             push,
  input  rpnp_pkg::item_t                  item,
  input  logic                             full,
  output rpnp_pkg::pair_wr_t               wr
);
  import rpnp_pkg::*;

  // Caps fitted to the register widths
  localparam logic [SPECIES_W-1:0] SPECIES_CAP =
    (MAX_SPECIES >= (1 << SPECIES_W) - 1) ? {SPECIES_W{1'b1}} : SPECIES_W'(MAX_SPECIES);
  localparam logic [SITE_W-1:0] SITE_CAP =
    (MAX_SITES >= (1 << SITE_W) - 1) ? {SITE_W{1'b1}} : SITE_W'(MAX_SITES);

  logic [SPECIES_W-1:0] species_total;
  logic [SITE_W-1:0]    site_total;

  logic                 in_name, in_name_next;
  logic                 name_seen, name_seen_next;
  logic [SPECIES_W-1:0] rows_done, rows_done_next;
  logic [SITE_W-1:0]    site_pos, site_pos_next;
  logic [2:0]           held_nibble, held_nibble_next;

  logic [SPECIES_W-1:0] row_lim;
  logic [SITE_W-1:0]    site_lim;
  logic                 take;
  logic                 flush;
  logic [SPECIES_W-1:0] rows_fin;
  logic [2:0]           st;
  result_t              half_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      species_total <= SPECIES_W'(1);
      site_total    <= SITE_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == REG_SPECIES_TOTAL) species_total <= cfg_data[SPECIES_W-1:0];
      else if (cfg_index == REG_SITE_TOTAL) site_total <= cfg_data;
    end
  end

  assign row_lim  = (species_total < SPECIES_CAP) ? species_total : SPECIES_CAP;
  assign site_lim = (site_total < SITE_CAP) ? site_total : SITE_CAP;
  assign take     = push & ~full;
  assign st       = base_state(item.text_byte);

  // Pending half byte closed with a gap in the high nibble
  assign half_res = make_result(KIND_PACKED, rows_done, site_pos[BIDX_W:1],
                                {1'b0, GAP_STATE, 1'b0, held_nibble}, 1'b0, 1'b0);

  // Finish bookkeeping
  assign flush    = (rows_done < row_lim) & name_seen & ~in_name;
  assign rows_fin = rows_done + SPECIES_W'(flush);

  // Classify the byte, update line state and build results
  always_comb begin
    in_name_next     = in_name;
    name_seen_next   = name_seen;
    rows_done_next   = rows_done;
    site_pos_next    = site_pos;
    held_nibble_next = held_nibble;
    wr               = '0;
    if (take) begin
      if (item.action) begin
        wr.valid = 1'b1;
        if (flush && site_pos[0]) begin
          wr.entry.two    = 1'b1;
          wr.entry.first  = half_res;
          wr.entry.second = make_result(KIND_FINISH, rows_fin, '0, 8'h00,
                                        rows_fin == species_total, 1'b1);
        end else begin
          wr.entry.first  = make_result(KIND_FINISH, rows_fin, '0, 8'h00,
                                        rows_fin == species_total, 1'b1);
        end
        rows_done_next   = '0;
        in_name_next     = 1'b1;
        name_seen_next   = 1'b0;
        site_pos_next    = '0;
        held_nibble_next = '0;
      end else if (rows_done < row_lim) begin
        priority if (item.text_byte == CH_LF) begin
          wr.valid = 1'b1;
          if (site_pos[0]) begin
            wr.entry.two    = 1'b1;
            wr.entry.first  = half_res;
            wr.entry.second = make_result(KIND_LINE_END, rows_done, '0, 8'h00,
                                          name_seen & ~in_name, 1'b1);
          end else begin
            wr.entry.first  = make_result(KIND_LINE_END, rows_done, '0, 8'h00,
                                          name_seen & ~in_name, 1'b1);
          end
          if (name_seen && !in_name) rows_done_next = rows_done + SPECIES_W'(1);
          in_name_next     = 1'b1;
          name_seen_next   = 1'b0;
          site_pos_next    = '0;
          held_nibble_next = '0;
        end else if (item.text_byte == CH_CR) begin
          // dropped
        end else if (item.text_byte == CH_SPACE || item.text_byte == CH_TAB) begin
          // blank closes a nonempty name; elsewhere dropped
          if (in_name && name_seen) in_name_next = 1'b0;
        end else if (in_name) begin
          name_seen_next = 1'b1;
          wr.valid       = 1'b1;
          wr.entry.first = make_result(KIND_NAME, rows_done, '0, item.text_byte,
                                       1'b0, 1'b1);
        end else if (site_pos < site_lim) begin
          if (!site_pos[0]) begin
            held_nibble_next = st;
          end else begin
            wr.valid         = 1'b1;
            wr.entry.first   = make_result(KIND_PACKED, rows_done, site_pos[BIDX_W:1],
                                           {1'b0, st, 1'b0, held_nibble}, 1'b0, 1'b1);
            held_nibble_next = '0;
          end
          site_pos_next = site_pos + SITE_W'(1);
        end else begin
          // bases past the site limit are dropped
        end
      end
    end
  end

  // Line state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_name     <= 1'b1;
      name_seen   <= 1'b0;
      rows_done   <= '0;
      site_pos    <= '0;
      held_nibble <= '0;
    end else begin
      in_name     <= in_name_next;
      name_seen   <= name_seen_next;
      rows_done   <= rows_done_next;
      site_pos    <= site_pos_next;
      held_nibble <= held_nibble_next;
    end
  end

endmodule

// File: design/rpnp_queue.sv
`timescale 1ns / 1ps
module rpnp_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  rpnp_pkg::pair_wr_t  wr,
  output logic                full,
  input  logic                rd,
  output rpnp_pkg::pair_t     head,
  output logic                avail
);
  import rpnp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pair_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full  = (count == CW'(DEPTH));
  assign avail = (count != '0);
  assign head  = slots[rd_ptr];
  assign do_wr = wr.valid & ~full;
  assign do_rd = rd & avail;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr.entry;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_wr && !do_rd) count <= count + CW'(1);
      else if (do_rd && !do_wr) count <= count - CW'(1);
    end
  end

endmodule

// File: design/rpnp_back.sv
`timescale 1ns / 1ps
module rpnp_back (
  input  logic              clk,
  input  logic              rst,
  input  rpnp_pkg::pair_t   head,
  input  logic              avail,
  output logic              rd,
  input  logic              pop,
  output logic              empty,
  output rpnp_pkg::result_t result
);
  import rpnp_pkg::*;

  pair_t cur;
  logic  held;
  logic  slot;
  logic  beat;
  logic  done;

  assign empty  = ~held;
  assign result = slot ? cur.second : cur.first;
  assign beat   = pop & held;
  assign done   = beat & (~cur.two | slot);
  assign rd     = avail & (~held | done);

  // Output register, one result per beat
  always_ff @(posedge clk) begin
    if (rd) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      slot <= 1'b0;
    end else if (rd) begin
      held <= 1'b1;
      slot <= 1'b0;
    end else if (done) begin
      held <= 1'b0;
      slot <= 1'b0;
    end else if (beat) begin
      slot <= 1'b1;
    end
  end

endmodule

// File: design/phylip_row_parser_nibble_packer.sv
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// item      push / full             action, text_byte
// result    empty / pop             kind, row_index, byte_index, value, accepted, last
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte per cycle is taken while full is low; the front parser updates its line state
// in the cycle of acceptance. An item's first result reaches the result port through the
// entry queue and then the output register; a two-result item occupies the port for two
// beats.
// Synchronous reset clears parser state, queue and output valid flag; config returns to 1.
// full rises only when the queue holds QUEUE_DEPTH entries awaiting pop.
module phylip_row_parser_nibble_packer #(
  parameter int MAX_SPECIES = rpnp_pkg::MAX_SPECIES_DEF,
  parameter int MAX_SITES   = rpnp_pkg::MAX_SITES_DEF,
  parameter int QUEUE_DEPTH = rpnp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rpnp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpnp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            push,
  output logic                            full,
  input  rpnp_pkg::item_t                 item,
  output logic                            empty,
  input  logic                            pop,
  output rpnp_pkg::result_t               result
);
  import rpnp_pkg::*;
  `include "assert_macros.svh"

  pair_wr_t q_wr;
  logic     q_full;
  logic     q_rd;
  pair_t    q_head;
  logic     q_avail;

  assign cfg_ready = 1'b1;
  assign full      = q_full;

  rpnp_front #(
    .MAX_SPECIES (MAX_SPECIES),
    .MAX_SITES   (MAX_SITES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .item      (item),
    .full      (q_full),
    .wr        (q_wr)
  );

  rpnp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .full  (q_full),
    .rd    (q_rd),
    .head  (q_head),
    .avail (q_avail)
  );

  rpnp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (q_head),
    .avail  (q_avail),
    .rd     (q_rd),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  // Checks
  `ASSERT_IMPLY(a_no_overflow, clk, rst, q_wr.valid, !q_full, "queue write while full")
  `ASSERT_IMPLY(a_pair_last, clk, rst, q_wr.valid && q_wr.entry.two,
                !q_wr.entry.first.last && q_wr.entry.second.last, "bad last marks in pair")
  `ASSERT_NEXT(a_pair_follows, clk, rst, !empty && pop && !result.last,
               !empty && result.last, "second result of pair missing")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rpnp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int SPECIES_CAP  = MAX_SPECIES_DEF;
  localparam int SITES_CAP    = MAX_SITES_DEF;
  localparam int PHASE_ITEMS  = 450;
  localparam int PRINT_CAP    = 50;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  push;
  logic                  full;
  item_t                 item;
  logic                  empty;
  logic                  pop;
  result_t               result;

  phylip_row_parser_nibble_packer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  // Parser mirror: registers and line state
  logic [SPECIES_W-1:0] cfg_species;
  logic [SITE_W-1:0]    cfg_sites;
  bit                   name_open;
  bit                   name_started;
  logic [SPECIES_W-1:0] rows_counted;
  logic [SITE_W-1:0]    base_count;
  logic [2:0]           low_nibble;

  result_t due_results[$];
  result_t want;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      mismatch_count;
  int      cycle_count;
  int      sent_items;
  string   alphabet = "ACGTacgt01234-";

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycle_count,
               due_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string field, input int got, input int wanted);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch in %s at cycle %0d: got %0h, want %0h", field, cycle_count,
               got, wanted);
    mismatch_count++;
  endtask

  // Compare each popped beat with the oldest due one
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected beat kind", result.kind, 0);
      end else begin
        want = due_results.pop_front();
        if (result.kind !== want.kind)
          report_mismatch("kind", result.kind, want.kind);
        if (result.row_index !== want.row_index)
          report_mismatch("row_index", result.row_index, want.row_index);
        if (result.byte_index !== want.byte_index)
          report_mismatch("byte_index", result.byte_index, want.byte_index);
        if (result.value !== want.value)
          report_mismatch("value", result.value, want.value);
        if (result.accepted !== want.accepted)
          report_mismatch("accepted", result.accepted, want.accepted);
        if (result.last !== want.last)
          report_mismatch("last", result.last, want.last);
      end
    end
  end

  function automatic void restart_line();
    name_open    = 1'b1;
    name_started = 1'b0;
    base_count   = '0;
    low_nibble   = '0;
  endfunction

  function automatic void queue_beat(input kind_t k, input logic [SPECIES_W-1:0] row,
                                     input logic [BIDX_W-1:0] bidx, input logic [7:0] val,
                                     input logic acc, input logic lst);
    result_t r;
    r.kind       = k;
    r.row_index  = row;
    r.byte_index = bidx;
    r.value      = val;
    r.accepted   = acc;
    r.last       = lst;
    due_results.insert(due_results.size(), r);
  endfunction

  // Base letter to 3-bit state; anything unknown is a gap
  function automatic logic [2:0] state_of(input logic [7:0] c);
    case (c)
      "A", "a", "0": return 3'd0;
      "C", "c", "1": return 3'd1;
      "G", "g", "2": return 3'd2;
      "T", "t", "3": return 3'd3;
      default:       return GAP_STATE;
    endcase
  endfunction

  // Work out the beats that one accepted byte (or end marker) produces
  function automatic void compute_parse_results(input item_t it);
    int unsigned row_limit;
    int unsigned site_limit;
    logic [7:0]  c;
    logic [7:0]  half_byte;
    bit          counted;
    c          = it.text_byte;
    row_limit  = (cfg_species < SPECIES_CAP) ? cfg_species : SPECIES_CAP;
    site_limit = (cfg_sites < SITES_CAP) ? cfg_sites : SITES_CAP;
    half_byte  = {1'b0, GAP_STATE, 1'b0, low_nibble};

    // End of input: flush an open sequence line, then finish
    if (it.action) begin
      if (rows_counted < row_limit && name_started && !name_open) begin
        if (base_count[0])
          queue_beat(KIND_PACKED, rows_counted, base_count[BIDX_W:1], half_byte, 1'b0, 1'b0);
        rows_counted++;
      end
      queue_beat(KIND_FINISH, rows_counted, '0, '0, rows_counted == cfg_species, 1'b1);
      rows_counted = '0;
      restart_line();
      return;
    end

    if (rows_counted >= row_limit) return;

    if (c == CH_LF) begin
      counted = name_started && !name_open;
      if (base_count[0])
        queue_beat(KIND_PACKED, rows_counted, base_count[BIDX_W:1], half_byte, 1'b0, 1'b0);
      queue_beat(KIND_LINE_END, rows_counted, '0, '0, counted, 1'b1);
      if (counted) rows_counted++;
      restart_line();
      return;
    end
    if (c == CH_CR) return;

    if (name_open) begin
      if (c == CH_SPACE || c == CH_TAB) begin
        if (name_started) begin
          name_open  = 1'b0;
          base_count = '0;
          low_nibble = '0;
        end
        return;
      end
      name_started = 1'b1;
      queue_beat(KIND_NAME, rows_counted, '0, c, 1'b0, 1'b1);
      return;
    end

    if (c == CH_SPACE || c == CH_TAB) return;
    if (base_count >= site_limit) return;

    // Pair two states per byte, low nibble first
    if (!base_count[0]) begin
      low_nibble = state_of(c);
    end else begin
      queue_beat(KIND_PACKED, rows_counted, base_count[BIDX_W:1],
                 {1'b0, state_of(c), 1'b0, low_nibble}, 1'b0, 1'b1);
      low_nibble = '0;
    end
    base_count++;
  endfunction

  // Send one beat with random gaps ahead of it; push stays high for back-to-back beats
  task automatic send_beat(input logic act, input logic [7:0] ch);
    item_t it;
    it.action    = act;
    it.text_byte = ch;
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    sent_items++;
    compute_parse_results(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i]);
  endtask

  task automatic send_end();
    send_beat(1'b1, 8'($urandom_range(255)));
  endtask

  // Register write only once the parser has drained
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    push <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SPECIES_TOTAL) cfg_species = data[SPECIES_W-1:0];
    else cfg_sites = data[SITE_W-1:0];
  endtask

  function automatic logic [7:0] blank_char();
    return $urandom_range(1) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CH_LF || c == CH_CR || c == CH_SPACE || c == CH_TAB);
    return c;
  endfunction

  // Mostly real bases, some junk, blanks and CRs
  function automatic logic [7:0] seq_char();
    logic [7:0] c;
    int         pick;
    pick = $urandom_range(9);
    if (pick < 7) return alphabet[$urandom_range(alphabet.len() - 1)];
    if (pick == 8) return blank_char();
    if (pick == 9) return CH_CR;
    do c = 8'($urandom_range(255)); while (c == CH_LF);
    return c;
  endfunction

  // Name split, blanks, CR, junk base, site cutoff, half byte flush, empty and
  // name-only lines, unterminated last line
  task automatic test_line_split();
    write_register(REG_SPECIES_TOTAL, 2);
    write_register(REG_SITE_TOTAL, 3);
    send_beat(1'b0, 8'h00);
    send_text("N");
    send_beat(1'b0, CH_SPACE);
    send_beat(1'b0, CH_SPACE);
    send_text("Ac");
    send_beat(1'b0, 8'hFF);
    send_beat(1'b0, CH_CR);
    send_text("G");
    send_beat(1'b0, CH_LF);
    send_beat(1'b0, CH_TAB);
    send_beat(1'b0, CH_LF);
    send_text("x");
    send_beat(1'b0, CH_LF);
    send_text("y");
    send_beat(1'b0, CH_TAB);
    send_text("T");
    send_end();
  endtask

  // Bytes after the last expected row are dropped
  task automatic test_species_limit();
    write_register(REG_SPECIES_TOTAL, 1);
    send_text("q 4");
    send_beat(1'b0, CH_LF);
    send_text("z");
    send_end();
  endtask

  // Zero row count, zero site count, count above the row cap
  task automatic test_count_extremes();
    write_register(REG_SPECIES_TOTAL, 0);
    send_text("a");
    send_end();
    write_register(REG_SPECIES_TOTAL, 2047);
    write_register(REG_SITE_TOTAL, 0);
    send_text("n A");
    send_end();
  endtask

  task automatic send_random_file();
    int n_lines;
    if ($urandom_range(1)) begin
      case ($urandom_range(9))
        0:       write_register(REG_SPECIES_TOTAL, 0);
        1:       write_register(REG_SPECIES_TOTAL, SPECIES_CAP);
        2:       write_register(REG_SPECIES_TOTAL, 2047);
        default: write_register(REG_SPECIES_TOTAL, $urandom_range(1, 5));
      endcase
      case ($urandom_range(9))
        0:       write_register(REG_SITE_TOTAL, 0);
        1:       write_register(REG_SITE_TOTAL, 1);
        2:       write_register(REG_SITE_TOTAL, SITES_CAP);
        3:       write_register(REG_SITE_TOTAL, 131071);
        default: write_register(REG_SITE_TOTAL, $urandom_range(2, 12));
      endcase
    end
    n_lines = $urandom_range(1, 6);
    for (int ln = 0; ln < n_lines; ln++) begin
      if ($urandom_range(9) == 0) begin
        // noise, may contain early end markers
        repeat ($urandom_range(1, 8))
          send_beat($urandom_range(29) == 0, 8'($urandom_range(255)));
      end else begin
        if ($urandom_range(9) == 0) send_beat(1'b0, blank_char());
        repeat ($urandom_range(1, 5)) send_beat(1'b0, name_char());
        repeat ($urandom_range(1, 2)) send_beat(1'b0, blank_char());
        repeat ($urandom_range(0, 14)) send_beat(1'b0, seq_char());
        if (ln < n_lines - 1 || $urandom_range(2) != 0) send_beat(1'b0, CH_LF);
      end
    end
    send_end();
  endtask

  task automatic test_random_files(input int send_pct, input int recv_pct);
    int start_n;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start_n = sent_items;
    while (sent_items - start_n < PHASE_ITEMS) send_random_file();
  endtask

  initial begin
    rst            = 1'b1;
    push           = 1'b0;
    item           = '0;
    pop            = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    cycle_count    = 0;
    mismatch_count = 0;
    sent_items     = 0;
    send_idle_pct  = 30;
    recv_idle_pct  = 74;
    cfg_species    = 1;
    cfg_sites      = 1;
    rows_counted   = '0;
    restart_line();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_line_split();
    test_species_limit();
    test_count_extremes();
    test_random_files(30, 74);
    test_random_files(74, 30);
    test_random_files(0, 0);

    // Drain, then give late strays a chance to show up
    push <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
